[src/gdb_pkg.sv]
// Shared types and constants for the graph traversal block.
// No dependencies; imported by every module of the block.
package gdb_pkg;

  localparam int NODES     = 32;  // vertices in use, 2..32
  localparam int MAX_NODES = 32;  // rows, row width and stack/queue depth
  localparam int VTX_W     = 5;
  localparam int CNT_W     = 6;   // stack depth and queue pointers, 0..32

  localparam logic [MAX_NODES-1:0] VALID_MASK =
    MAX_NODES'((64'(1) << NODES) - 64'(1));

  localparam logic KIND_DFS = 1'b0;
  localparam logic KIND_BFS = 1'b1;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_RUN   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } gdb_op_t;

  typedef struct packed {
    gdb_op_t          operation;
    logic [VTX_W-1:0] vertex_a;
    logic [VTX_W-1:0] vertex_b;
  } gdb_in_t;

  typedef struct packed {
    logic             order_kind;
    logic [VTX_W-1:0] vertex;
    logic             end_of_order;
    logic             last;
  } gdb_out_t;

  typedef struct packed {
    logic             found;
    logic [VTX_W-1:0] idx;
  } gdb_scan_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DFS_STK,
    ST_DFS_ROW,
    ST_DFS_SCAN,
    ST_DFS_END,
    ST_BFS_Q,
    ST_BFS_ROW,
    ST_BFS_SCAN,
    ST_BFS_EMIT
  } gdb_state_t;

  function automatic logic [MAX_NODES-1:0] vtx_bit(logic [VTX_W-1:0] v);
    return MAX_NODES'(1) << v;
  endfunction

endpackage

[src/gdb_scan.sv]
// Lowest-set-bit search over one candidate row.
// Depends on gdb_pkg.
module gdb_scan (
  input  logic [gdb_pkg::MAX_NODES-1:0] cand,
  output gdb_pkg::gdb_scan_t            res
);
  import gdb_pkg::*;

  always_comb begin
    res = '0;
    // walk from the top so the lowest set bit wins
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (cand[i]) begin
        res.found = 1'b1;
        res.idx   = VTX_W'(i);
      end
    end
  end

endmodule

[src/graph_dfs_bfs_order.sv]
// Graph traversal block: adjacency matrix, DFS stack, BFS queue and sequencer.
// Depends on gdb_pkg and gdb_scan.
//
// Add-edge and clear items are applied in the idle state and leave the block
// idle. A run item emits the depth-first order and then the breadth-first
// order, one beat per visited vertex. Both searches share one lowest-bit scan
// unit under a sequencer: each DFS push or pop takes a stack read, a row read
// and a scan; each dequeued BFS vertex takes a queue read, a row read, one
// scan per enqueued neighbor plus a final empty scan, and an emit. A run
// waits while the result side stalls. The block takes no new item during a
// run.
module graph_dfs_bfs_order (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  gdb_pkg::gdb_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output gdb_pkg::gdb_out_t out_data
);
  import gdb_pkg::*;

  gdb_state_t             state_r, state_nxt;
  logic [MAX_NODES-1:0]   adj_r [MAX_NODES];
  logic [MAX_NODES-1:0]   adj_nxt [MAX_NODES];
  logic [MAX_NODES-1:0]   seen_r, seen_nxt;
  logic [MAX_NODES-1:0]   cand_r, cand_nxt;
  logic [CNT_W-1:0]       depth_r, depth_nxt;
  logic [CNT_W-1:0]       head_r, head_nxt;
  logic [CNT_W-1:0]       tail_r, tail_nxt;
  logic [VTX_W-1:0]       start_r, start_nxt;
  gdb_out_t               pend_r, pend_nxt;
  gdb_out_t               out_r, out_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic [VTX_W-1:0]       stk_mem [MAX_NODES];
  logic [VTX_W-1:0]       que_mem [MAX_NODES];
  logic [VTX_W-1:0]       stk_q_r, que_q_r;
  logic                   stk_we, stk_re, que_we, que_re;
  logic [VTX_W-1:0]       stk_wa, stk_wd, stk_ra, que_wa, que_wd, que_ra;

  gdb_scan_t              scan;
  logic                   slot_free;
  logic                   a_ok, b_ok;
  logic                   bfs_fin;
  logic [CNT_W-1:0]       depth_m1;

  gdb_scan u_scan (
    .cand (cand_r),
    .res  (scan)
  );

  assign slot_free = !out_valid_r || out_ready;
  assign a_ok      = CNT_W'(in_data.vertex_a) < CNT_W'(NODES);
  assign b_ok      = CNT_W'(in_data.vertex_b) < CNT_W'(NODES);
  assign bfs_fin   = (head_r == tail_r);
  assign depth_m1  = depth_r - CNT_W'(1);

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_NODES; i++) begin
        adj_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      adj_r       <= adj_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seen_r  <= seen_nxt;
    cand_r  <= cand_nxt;
    depth_r <= depth_nxt;
    head_r  <= head_nxt;
    tail_r  <= tail_nxt;
    start_r <= start_nxt;
    pend_r  <= pend_nxt;
    out_r   <= out_nxt;
  end

  // DFS stack and BFS queue, registered reads
  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    if (que_we) que_mem[que_wa] <= que_wd;
    if (stk_re) stk_q_r <= stk_mem[stk_ra];
    if (que_re) que_q_r <= que_mem[que_ra];
  end

  always_comb begin
    state_nxt     = state_r;
    adj_nxt       = adj_r;
    seen_nxt      = seen_r;
    cand_nxt      = cand_r;
    depth_nxt     = depth_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    start_nxt     = start_r;
    pend_nxt      = pend_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    stk_we        = 1'b0;
    stk_wa        = '0;
    stk_wd        = '0;
    stk_re        = 1'b0;
    stk_ra        = depth_m1[VTX_W-1:0];
    que_we        = 1'b0;
    que_wa        = '0;
    que_wd        = '0;
    que_re        = 1'b0;
    que_ra        = head_r[VTX_W-1:0];
    in_ready      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_data.operation)
            OP_ADD: begin
              if (a_ok && b_ok) begin
                for (int i = 0; i < MAX_NODES; i++) begin
                  if (in_data.vertex_a == VTX_W'(i))
                    adj_nxt[i] = adj_nxt[i] | vtx_bit(in_data.vertex_b);
                  if (in_data.vertex_b == VTX_W'(i))
                    adj_nxt[i] = adj_nxt[i] | vtx_bit(in_data.vertex_a);
                end
              end
            end
            OP_CLEAR: begin
              for (int i = 0; i < MAX_NODES; i++) begin
                adj_nxt[i] = '0;
              end
            end
            OP_RUN: begin
              if (a_ok) begin
                seen_nxt  = vtx_bit(in_data.vertex_a);
                stk_we    = 1'b1;
                stk_wa    = '0;
                stk_wd    = in_data.vertex_a;
                depth_nxt = CNT_W'(1);
                start_nxt = in_data.vertex_a;
                pend_nxt  = '{order_kind: KIND_DFS, vertex: in_data.vertex_a,
                              end_of_order: 1'b0, last: 1'b0};
                state_nxt = ST_DFS_STK;
              end
            end
            default: ;
          endcase
        end
      end

      ST_DFS_STK: begin
        stk_re    = 1'b1;
        state_nxt = ST_DFS_ROW;
      end

      ST_DFS_ROW: begin
        cand_nxt  = adj_r[stk_q_r] & ~seen_r & VALID_MASK;
        state_nxt = ST_DFS_SCAN;
      end

      ST_DFS_SCAN: begin
        if (scan.found) begin
          // the held beat goes out only now that it is known not to be last
          if (slot_free) begin
            out_nxt         = pend_r;
            out_valid_nxt   = 1'b1;
            pend_nxt.vertex = scan.idx;
            seen_nxt        = seen_r | vtx_bit(scan.idx);
            stk_we          = 1'b1;
            stk_wa          = depth_r[VTX_W-1:0];
            stk_wd          = scan.idx;
            depth_nxt       = depth_r + CNT_W'(1);
            state_nxt       = ST_DFS_STK;
          end
        end else begin
          depth_nxt = depth_m1;
          state_nxt = (depth_r == CNT_W'(1)) ? ST_DFS_END : ST_DFS_STK;
        end
      end

      ST_DFS_END: begin
        if (slot_free) begin
          out_nxt              = pend_r;
          out_nxt.end_of_order = 1'b1;
          out_valid_nxt        = 1'b1;
          seen_nxt             = vtx_bit(start_r);
          que_we               = 1'b1;
          que_wa               = '0;
          que_wd               = start_r;
          head_nxt             = '0;
          tail_nxt             = CNT_W'(1);
          state_nxt            = ST_BFS_Q;
        end
      end

      ST_BFS_Q: begin
        que_re    = 1'b1;
        head_nxt  = head_r + CNT_W'(1);
        state_nxt = ST_BFS_ROW;
      end

      ST_BFS_ROW: begin
        cand_nxt  = adj_r[que_q_r] & ~seen_r & VALID_MASK;
        state_nxt = ST_BFS_SCAN;
      end

      ST_BFS_SCAN: begin
        if (scan.found) begin
          // mark on enqueue, one neighbor per cycle in ascending order
          seen_nxt = seen_r | vtx_bit(scan.idx);
          cand_nxt = cand_r & ~vtx_bit(scan.idx);
          que_we   = 1'b1;
          que_wa   = tail_r[VTX_W-1:0];
          que_wd   = scan.idx;
          tail_nxt = tail_r + CNT_W'(1);
        end else begin
          state_nxt = ST_BFS_EMIT;
        end
      end

      ST_BFS_EMIT: begin
        if (slot_free) begin
          out_nxt       = '{order_kind: KIND_BFS, vertex: que_q_r,
                            end_of_order: bfs_fin, last: bfs_fin};
          out_valid_nxt = 1'b1;
          state_nxt     = bfs_fin ? ST_IDLE : ST_BFS_Q;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

[src/gdb_chk.sv]
// Port-level checks for graph_dfs_bfs_order, bound to the top level.
// Depends on gdb_pkg.
module gdb_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input gdb_pkg::gdb_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input gdb_pkg::gdb_out_t out_data
);
  import gdb_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // a run in range occupies the block
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.operation == OP_RUN &&
    CNT_W'(in_data.vertex_a) < CNT_W'(NODES) |=> !in_ready)
    else $error("ready right after a run beat");

  // the block stays ready after an edge add or clear
  a_edit_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready &&
    (in_data.operation == OP_ADD || in_data.operation == OP_CLEAR) |=> in_ready)
    else $error("block busy after an edit beat");

  // the final beat closes the BFS order
  a_last_bfs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |-> out_data.order_kind == KIND_BFS &&
    out_data.end_of_order)
    else $error("last flag on a beat that does not end the BFS order");

  // while idle, only the final beat of a run can still be waiting
  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && out_valid |-> out_data.last)
    else $error("non-final result pending while idle");

endmodule

bind graph_dfs_bfs_order gdb_chk u_gdb_chk (.*);

[tb/tb_graph_dfs_bfs_order.sv]
// Self-checking testbench for graph_dfs_bfs_order: directed table then random graph sessions,
// every result beat checked against listed beats or a behavioral DFS/BFS order predictor.
// Depends on gdb_pkg and the graph_dfs_bfs_order RTL.
module tb_graph_dfs_bfs_order;
  import gdb_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int ITEM_TARGET    = 130;
  localparam int SETTLE_CYCLES  = 400;

  typedef enum int {SHAPE_SCATTER, SHAPE_CHAIN, SHAPE_STAR, SHAPE_DENSE} shape_t;
  typedef enum int {RX_OPEN, RX_PATTERN, RX_RANDOM} rx_mode_t;

  // n_typed < 0: results come from the predictor; otherwise the row lists them
  typedef struct {
    gdb_in_t  item;
    int       n_typed;
    gdb_out_t t0;
    gdb_out_t t1;
  } dir_row_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  gdb_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  gdb_out_t out_data;

  logic [31:0] graph_rows [32];
  gdb_out_t    order_beats_due[$];
  dir_row_t    dir_rows[$];
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  int          burst_left = 0;
  int          items_sent = 0;

  rx_mode_t    rx_mode = RX_OPEN;
  int          rx_phase_left = 0;
  logic [7:0]  rx_pattern = 8'hff;

  graph_dfs_bfs_order dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic gdb_out_t mk_beat(logic kind, int v, logic eoo, logic fin);
    gdb_out_t b;
    b.order_kind   = kind;
    b.vertex       = VTX_W'(v);
    b.end_of_order = eoo;
    b.last         = fin;
    return b;
  endfunction

  function automatic gdb_in_t mk_item(gdb_op_t op, int a, int b);
    gdb_in_t it;
    it.operation = op;
    it.vertex_a  = VTX_W'(a);
    it.vertex_b  = VTX_W'(b);
    return it;
  endfunction

  function automatic dir_row_t row(gdb_op_t op, int a, int b, int n, gdb_out_t t0, gdb_out_t t1);
    dir_row_t r;
    r.item    = mk_item(op, a, b);
    r.n_typed = n;
    r.t0      = t0;
    r.t1      = t1;
    return r;
  endfunction

  function automatic void add_row(dir_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic void due_beat(gdb_out_t b);
    order_beats_due.insert(order_beats_due.size(), b);
  endfunction

  function automatic logic [4:0] lowest_set(logic [31:0] m);
    for (int i = 0; i < 32; i++) begin
      if (m[i]) begin
        return 5'(i);
      end
    end
    return 5'd0;
  endfunction

  function automatic void update_graph(gdb_in_t it);
    if (it.operation == OP_ADD) begin
      if (int'(it.vertex_a) < NODES && int'(it.vertex_b) < NODES) begin
        graph_rows[it.vertex_a][it.vertex_b] = 1'b1;
        graph_rows[it.vertex_b][it.vertex_a] = 1'b1;
      end
    end else if (it.operation == OP_CLEAR) begin
      foreach (graph_rows[i]) graph_rows[i] = '0;
    end
  endfunction

  // Depth-first then breadth-first visit order from start, lowest neighbor first.
  function automatic void traverse_from(logic [4:0] start);
    logic [31:0] node_mask;
    logic [31:0] seen;
    logic [31:0] cand;
    logic [4:0]  stk [32];
    logic [4:0]  fifo [32];
    logic [4:0]  v;
    logic [4:0]  x;
    int          depth;
    int          head;
    int          tail;
    gdb_out_t    beats[$];
    if (int'(start) >= NODES) begin
      return;
    end
    node_mask = 32'((64'd1 << NODES) - 64'd1);

    seen   = 32'd1 << start;
    stk[0] = start;
    depth  = 1;
    beats.insert(beats.size(), mk_beat(KIND_DFS, start, 1'b0, 1'b0));
    while (depth > 0) begin
      cand = graph_rows[stk[depth-1]] & ~seen & node_mask;
      if (cand != 0) begin
        v = lowest_set(cand);
        seen[v] = 1'b1;
        if (depth < 32) begin
          stk[depth] = v;
          depth++;
        end
        beats.insert(beats.size(), mk_beat(KIND_DFS, v, 1'b0, 1'b0));
      end else begin
        depth--;
      end
    end
    beats[beats.size()-1].end_of_order = 1'b1;

    // mark on enqueue
    seen    = 32'd1 << start;
    fifo[0] = start;
    head    = 0;
    tail    = 1;
    while (head < tail && head < 32) begin
      x = fifo[head];
      head++;
      beats.insert(beats.size(), mk_beat(KIND_BFS, x, 1'b0, 1'b0));
      cand = graph_rows[x] & ~seen & node_mask;
      while (cand != 0) begin
        v = lowest_set(cand);
        cand[v] = 1'b0;
        seen[v] = 1'b1;
        if (tail < 32) begin
          fifo[tail] = v;
          tail++;
        end
      end
    end
    beats[beats.size()-1].end_of_order = 1'b1;
    beats[beats.size()-1].last = 1'b1;

    foreach (beats[i]) due_beat(beats[i]);
  endfunction

  task automatic report_mismatch(string what, int got, int exp);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, exp);
    mismatch_count++;
  endtask

  task automatic check_beat(gdb_out_t got);
    gdb_out_t want;
    if (order_beats_due.size() == 0) begin
      report_mismatch("beat with nothing due, vertex", got.vertex, 0);
      return;
    end
    want = order_beats_due.pop_front();
    if (got.order_kind !== want.order_kind)
      report_mismatch("order_kind", got.order_kind, want.order_kind);
    if (got.vertex !== want.vertex)
      report_mismatch("vertex", got.vertex, want.vertex);
    if (got.end_of_order !== want.end_of_order)
      report_mismatch("end_of_order", got.end_of_order, want.end_of_order);
    if (got.last !== want.last)
      report_mismatch("last", got.last, want.last);
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_item(gdb_in_t it, int n_typed = -1, gdb_out_t t0 = '0,
                           gdb_out_t t1 = '0);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    if (n_typed < 0) begin
      update_graph(it);
      if (it.operation == OP_RUN) traverse_from(it.vertex_a);
    end else begin
      update_graph(it);
      if (n_typed > 0) due_beat(t0);
      if (n_typed > 1) due_beat(t1);
    end
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (order_beats_due.size() != 0);
    burst_left = 0;
  endtask

  // One graph build followed by a few runs; clears, stray ops and early runs as noise.
  task automatic graph_session(shape_t shape, int span);
    int lo;
    int n;
    int a;
    int b;
    int hub;
    lo = $urandom_range(0, 32 - span);
    if ($urandom_range(0, 2) == 0) begin
      send_item(mk_item(OP_CLEAR, $urandom_range(0, 31), $urandom_range(0, 31)));
      items_sent++;
    end
    case (shape)
      SHAPE_CHAIN: n = span - 1;
      SHAPE_STAR:  n = span - 1;
      SHAPE_DENSE: n = 2 * span;
      default:     n = $urandom_range(1, span);
    endcase
    hub = lo + $urandom_range(0, span - 1);
    for (int i = 0; i < n; i++) begin
      case (shape)
        SHAPE_CHAIN: begin
          a = lo + i;
          b = lo + i + 1;
        end
        SHAPE_STAR: begin
          a = hub;
          b = lo + i;
          if (b >= hub) b++;
        end
        default: begin
          a = lo + $urandom_range(0, span - 1);
          b = lo + $urandom_range(0, span - 1);
        end
      endcase
      if ($urandom_range(0, 1) == 0) begin
        send_item(mk_item(OP_ADD, a, b));
      end else begin
        send_item(mk_item(OP_ADD, b, a));
      end
      items_sent++;
      if ($urandom_range(0, 11) == 0) begin
        send_item(mk_item(OP_NONE, $urandom_range(0, 31), $urandom_range(0, 31)));
      end
      if ($urandom_range(0, 15) == 0) begin
        send_item(mk_item(OP_RUN, lo + $urandom_range(0, span - 1), $urandom_range(0, 31)));
        items_sent++;
      end
    end
    repeat ($urandom_range(1, 3)) begin
      a = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : lo + $urandom_range(0, span - 1);
      send_item(mk_item(OP_RUN, a, $urandom_range(0, 31)));
      items_sent++;
    end
  endtask

  // Receiver: open, rotating stall pattern or coin flip, switching every so often.
  always @(negedge clk) begin
    if (rx_phase_left == 0) begin
      rx_mode       = rx_mode_t'($urandom_range(0, 2));
      rx_pattern    = 8'($urandom_range(0, 255)) | 8'h01;
      rx_phase_left = $urandom_range(20, 120);
    end
    rx_phase_left--;
    case (rx_mode)
      RX_OPEN:    out_ready <= 1'b1;
      RX_PATTERN: begin
        out_ready  <= rx_pattern[0];
        rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
      end
      default:    out_ready <= 1'($urandom_range(0, 1));
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (out_valid && out_ready) check_beat(out_data);
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    shape_t   shape;
    int       span;
    int       sessions;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    foreach (graph_rows[i]) graph_rows[i] = '0;

    // an isolated start emits itself once per order
    add_row(row(OP_RUN, 0, 31, 2, mk_beat(KIND_DFS, 0, 1'b1, 1'b0),
                mk_beat(KIND_BFS, 0, 1'b1, 1'b1)));
    add_row(row(OP_RUN, 31, 0, 2, mk_beat(KIND_DFS, 31, 1'b1, 1'b0),
                mk_beat(KIND_BFS, 31, 1'b1, 1'b1)));
    add_row(row(OP_NONE, 31, 31, 0, '0, '0));
    add_row(row(OP_CLEAR, 0, 0, 0, '0, '0));
    add_row(row(OP_ADD, 0, 31, -1, '0, '0));
    add_row(row(OP_ADD, 31, 0, -1, '0, '0));
    add_row(row(OP_ADD, 31, 31, -1, '0, '0));
    add_row(row(OP_RUN, 0, 0, -1, '0, '0));
    add_row(row(OP_ADD, 0, 1, -1, '0, '0));
    add_row(row(OP_ADD, 1, 2, -1, '0, '0));
    add_row(row(OP_ADD, 2, 30, -1, '0, '0));
    add_row(row(OP_ADD, 1, 30, -1, '0, '0));
    add_row(row(OP_ADD, 0, 1, -1, '0, '0));
    add_row(row(OP_RUN, 0, 0, -1, '0, '0));
    add_row(row(OP_RUN, 30, 31, -1, '0, '0));
    add_row(row(OP_RUN, 15, 21, 2, mk_beat(KIND_DFS, 15, 1'b1, 1'b0),
                mk_beat(KIND_BFS, 15, 1'b1, 1'b1)));
    add_row(row(OP_NONE, 21, 10, 0, '0, '0));
    // self-loop alone leaves the vertex isolated
    add_row(row(OP_ADD, 16, 16, 0, '0, '0));
    add_row(row(OP_RUN, 16, 0, 2, mk_beat(KIND_DFS, 16, 1'b1, 1'b0),
                mk_beat(KIND_BFS, 16, 1'b1, 1'b1)));
    add_row(row(OP_CLEAR, 31, 31, 0, '0, '0));
    add_row(row(OP_RUN, 0, 0, 2, mk_beat(KIND_DFS, 0, 1'b1, 1'b0),
                mk_beat(KIND_BFS, 0, 1'b1, 1'b1)));
    add_row(row(OP_ADD, 10, 21, -1, '0, '0));
    add_row(row(OP_RUN, 21, 10, -1, '0, '0));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].item, dir_rows[i].n_typed, dir_rows[i].t0, dir_rows[i].t1);
      items_sent++;
    end
    wait_drained();

    // deepest stack and longest orders first, then mixed sessions
    graph_session(SHAPE_CHAIN, 32);
    wait_drained();
    sessions = 0;
    while (items_sent < ITEM_TARGET) begin
      shape = shape_t'($urandom_range(0, 3));
      span  = ($urandom_range(0, 5) == 0) ? 32 : $urandom_range(2, 10);
      graph_session(shape, span);
      sessions++;
      if (sessions == 3 || $urandom_range(0, 4) == 0) wait_drained();
    end

    in_valid <= 1'b0;
    while (order_beats_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
